>>> rtl/core/ptvb_pkg.sv
// ----------------------------------------------------------------------------
// ptvb_pkg
// shared types, constants and command/status bundles of the top-k view blend
// ----------------------------------------------------------------------------
package ptvb_pkg;

  localparam int MaxPointsDef  = 4096;
  localparam int MaxKeepDef    = 8;
  localparam int MaxCamerasDef = 256;

  localparam int PT_W  = 12;
  localparam int WT_W  = 16;
  localparam int CH_W  = 8;
  localparam int CAM_W = 8;
  localparam int INT_W = 8;
  // count and entry index width covering the largest keep count
  localparam int CNT_W = 5;

  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 64;

  localparam logic CFG_BLEND_MODE = 1'b0;
  localparam logic CFG_REQ_KEEP   = 1'b1;

  localparam logic MODE_OFFER    = 1'b0;
  localparam logic MODE_FINALIZE = 1'b1;

  localparam logic [1:0] RK_GRAY   = 2'd0;
  localparam logic [1:0] RK_SINGLE = 2'd1;
  localparam logic [1:0] RK_BLEND  = 2'd2;

  typedef struct packed {
    logic [CAM_W-1:0] cam;
    logic [CH_W-1:0]  b;
    logic [CH_W-1:0]  g;
    logic [CH_W-1:0]  r;
    logic [WT_W-1:0]  w;
  } cand_t;

  typedef struct packed {
    logic             load_item;
    logic             cnt_wr;
    logic [CNT_W-1:0] cnt_wdata;
    logic             tbl_rd;
    logic [CNT_W-1:0] tbl_ridx;
    logic             tbl_wr;
    logic [CNT_W-1:0] tbl_widx;
    logic             tbl_wnew;
    logic             acc_clr;
    logic             acc_en;
    logic             div_start;
    logic             div_step;
    logic             out_load;
    logic [1:0]       out_kind;
    logic             clr_step;
  } cmd_t;

  typedef struct packed {
    logic             mode;
    logic             offer_ok;
    logic             pt_ok;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] keep;
    logic             rd_ge;
    logic             blend;
    logic             clr_last;
    logic             div_last;
    logic             out_free;
  } sts_t;

endpackage

>>> rtl/core/ptvb_ctrl.sv
// ----------------------------------------------------------------------------
// ptvb_ctrl
// sequencer for count clearing, sorted insertion, accumulation and division
// ----------------------------------------------------------------------------
module ptvb_ctrl
  import ptvb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_valid_i,
  output logic s_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CNT   = 4'd2;
  localparam logic [3:0] S_REPL  = 4'd3;
  localparam logic [3:0] S_WALK  = 4'd4;
  localparam logic [3:0] S_PUT0  = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;
  localparam logic [3:0] S_FPOST = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [1:0]       kind_q, kind_d;

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    i_d     = i_q;
    n_d     = n_q;
    kind_d  = kind_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_CNT;
        end
      end
      S_CNT: begin
        n_d = sts_i.cnt;
        if (sts_i.mode == MODE_OFFER) begin
          if (!sts_i.offer_ok) begin
            state_d = S_IDLE;
          end else if (sts_i.cnt < sts_i.keep) begin
            cmd_o.cnt_wr    = 1'b1;
            cmd_o.cnt_wdata = sts_i.cnt + CNT_W'(1);
            if (sts_i.cnt == '0) begin
              cmd_o.tbl_wr   = 1'b1;
              cmd_o.tbl_widx = '0;
              cmd_o.tbl_wnew = 1'b1;
              state_d = S_IDLE;
            end else begin
              cmd_o.tbl_rd   = 1'b1;
              cmd_o.tbl_ridx = sts_i.cnt - CNT_W'(1);
              i_d = sts_i.cnt - CNT_W'(1);
              state_d = S_WALK;
            end
          end else if (sts_i.cnt != '0) begin
            cmd_o.tbl_rd   = 1'b1;
            cmd_o.tbl_ridx = sts_i.cnt - CNT_W'(1);
            state_d = S_REPL;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          if (!sts_i.pt_ok || sts_i.cnt == '0) begin
            kind_d  = RK_GRAY;
            state_d = S_EMIT;
          end else begin
            cmd_o.cnt_wr    = 1'b1;
            cmd_o.cnt_wdata = '0;
            cmd_o.acc_clr   = 1'b1;
            cmd_o.tbl_rd    = 1'b1;
            cmd_o.tbl_ridx  = '0;
            i_d = '0;
            state_d = S_FRD;
          end
        end
      end
      S_REPL: begin
        if (sts_i.rd_ge) begin
          state_d = S_IDLE;
        end else if (n_q == CNT_W'(1)) begin
          cmd_o.tbl_wr   = 1'b1;
          cmd_o.tbl_widx = '0;
          cmd_o.tbl_wnew = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.tbl_rd   = 1'b1;
          cmd_o.tbl_ridx = n_q - CNT_W'(2);
          i_d = n_q - CNT_W'(2);
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.tbl_wr   = 1'b1;
        cmd_o.tbl_widx = i_q + CNT_W'(1);
        if (sts_i.rd_ge) begin
          cmd_o.tbl_wnew = 1'b1;
          state_d = S_IDLE;
        end else if (i_q == '0) begin
          state_d = S_PUT0;
        end else begin
          cmd_o.tbl_rd   = 1'b1;
          cmd_o.tbl_ridx = i_q - CNT_W'(1);
          i_d = i_q - CNT_W'(1);
        end
      end
      S_PUT0: begin
        cmd_o.tbl_wr   = 1'b1;
        cmd_o.tbl_widx = '0;
        cmd_o.tbl_wnew = 1'b1;
        state_d = S_IDLE;
      end
      S_FRD: begin
        cmd_o.acc_en = 1'b1;
        if (i_q == n_q - CNT_W'(1)) begin
          state_d = S_FPOST;
        end else begin
          cmd_o.tbl_rd   = 1'b1;
          cmd_o.tbl_ridx = i_q + CNT_W'(1);
          i_d = i_q + CNT_W'(1);
        end
      end
      S_FPOST: begin
        if (!sts_i.blend || n_q == CNT_W'(1)) begin
          kind_d  = RK_SINGLE;
          state_d = S_EMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          kind_d  = RK_BLEND;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = kind_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      i_q     <= '0;
      n_q     <= '0;
      kind_q  <= RK_GRAY;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      n_q     <= n_d;
      kind_q  <= kind_d;
    end
  end

endmodule

>>> rtl/core/ptvb_dp.sv
// ----------------------------------------------------------------------------
// ptvb_dp
// item registers, count and candidate memories, accumulators, divider, output
// ----------------------------------------------------------------------------
module ptvb_dp
  import ptvb_pkg::*;
#(
  parameter int MAX_POINTS  = MaxPointsDef,
  parameter int MAX_KEEP    = MaxKeepDef,
  parameter int MAX_CAMERAS = MaxCamerasDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic                 s_tuser_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_index_i,
  input  logic [3:0]           cfg_data_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic [M_TDATA_W-1:0] m_tdata_o,
  output logic                 m_tuser_o
);

  localparam int PA_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int KA_W  = $clog2(MAX_KEEP);
  localparam int CW    = $clog2(MAX_KEEP + 1);
  localparam int TD    = MAX_POINTS << KA_W;
  localparam int SUM_W = WT_W + CW;
  localparam int NUM_W = SUM_W + CH_W;
  localparam int DC_W  = $clog2(CH_W);

  // input unpack
  logic [PT_W-1:0]  in_pt;
  cand_t            in_c;
  logic [INT_W-1:0] in_int;
  assign in_pt    = s_tdata_i[11:0];
  assign in_c.w   = s_tdata_i[27:12];
  assign in_c.r   = s_tdata_i[35:28];
  assign in_c.g   = s_tdata_i[43:36];
  assign in_c.b   = s_tdata_i[51:44];
  assign in_c.cam = s_tdata_i[59:52];
  assign in_int   = s_tdata_i[67:60];

  logic             mode_q;
  logic [PT_W-1:0]  pt_q;
  cand_t            c_q;
  logic [INT_W-1:0] int_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q <= s_tuser_i;
      pt_q   <= in_pt;
      c_q    <= in_c;
      int_q  <= in_int;
    end
  end

  // configuration
  logic       blend_q;
  logic [3:0] req_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_q <= 1'b0;
      req_q   <= 4'd2;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_BLEND_MODE) blend_q <= cfg_data_i[0];
      else if (cfg_index_i == CFG_REQ_KEEP) req_q <= cfg_data_i;
    end
  end

  logic [CNT_W-1:0] keep;
  always_comb begin
    if (!blend_q) keep = CNT_W'(1);
    else if (req_q < 4'd2) keep = CNT_W'(2);
    else if (32'(req_q) > 32'(MAX_KEEP)) keep = CNT_W'(MAX_KEEP);
    else keep = CNT_W'(req_q);
  end

  logic            pt_ok;
  logic [PA_W-1:0] pt_addr;
  logic [PA_W-1:0] in_addr;
  assign pt_ok   = 32'(pt_q) < 32'(MAX_POINTS);
  assign pt_addr = PA_W'(pt_q);
  assign in_addr = PA_W'(in_pt);

  // count memory with clearing sweep after reset
  logic [CW-1:0]   cnt_mem [MAX_POINTS];
  logic [CW-1:0]   cnt_rd_q;
  logic [PA_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_addr_q <= '0;
    else if (cmd_i.clr_step) clr_addr_q <= clr_addr_q + PA_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) cnt_mem[clr_addr_q] <= '0;
    else if (cmd_i.cnt_wr) cnt_mem[pt_addr] <= CW'(cmd_i.cnt_wdata);
    if (cmd_i.load_item) cnt_rd_q <= cnt_mem[in_addr];
  end

  // candidate memory
  cand_t tbl_mem [TD];
  cand_t rd_q;
  logic [PA_W+KA_W-1:0] raddr, waddr;
  assign raddr = {pt_addr, cmd_i.tbl_ridx[KA_W-1:0]};
  assign waddr = {pt_addr, cmd_i.tbl_widx[KA_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_wr) tbl_mem[waddr] <= cmd_i.tbl_wnew ? c_q : rd_q;
    if (cmd_i.tbl_rd) rd_q <= tbl_mem[raddr];
  end

  // accumulation
  logic [SUM_W-1:0]       s_q;
  logic [NUM_W-1:0]       num_q [3];
  logic [WT_W+CH_W-1:0]   prod [3];
  cand_t                  win_q;
  logic                   first_q;

  assign prod[0] = rd_q.w * rd_q.r;
  assign prod[1] = rd_q.w * rd_q.g;
  assign prod[2] = rd_q.w * rd_q.b;

  // divider, one quotient bit per step
  logic [NUM_W-1:0] rem_q [3];
  logic [NUM_W-1:0] d_q;
  logic [CH_W-1:0]  quo_q [3];
  logic [DC_W-1:0]  dcnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      s_q     <= '0;
      first_q <= 1'b1;
      for (int c = 0; c < 3; c++) num_q[c] <= '0;
    end else if (cmd_i.acc_en) begin
      s_q     <= s_q + SUM_W'(rd_q.w);
      first_q <= 1'b0;
      if (first_q) win_q <= rd_q;
      for (int c = 0; c < 3; c++) num_q[c] <= num_q[c] + NUM_W'(prod[c]);
    end
    if (cmd_i.div_start) begin
      d_q    <= NUM_W'(s_q) << (CH_W - 1);
      dcnt_q <= DC_W'(CH_W - 1);
      for (int c = 0; c < 3; c++) begin
        rem_q[c] <= num_q[c] + NUM_W'(s_q >> 1);
        quo_q[c] <= '0;
      end
    end else if (cmd_i.div_step) begin
      d_q    <= d_q >> 1;
      dcnt_q <= dcnt_q - DC_W'(1);
      for (int c = 0; c < 3; c++) begin
        if (rem_q[c] >= d_q) begin
          rem_q[c] <= rem_q[c] - d_q;
          quo_q[c] <= {quo_q[c][CH_W-2:0], 1'b1};
        end else begin
          quo_q[c] <= {quo_q[c][CH_W-2:0], 1'b0};
        end
      end
    end
  end

  // output register
  logic             ov_q;
  logic [PT_W-1:0]  opt_q;
  logic [CH_W-1:0]  or_q, og_q, ob_q;
  logic             ocol_q;
  logic [CAM_W-1:0] ocam_q;
  logic [WT_W-1:0]  ow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd_i.out_load) ov_q <= 1'b1;
    else if (m_ready_i) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      opt_q <= pt_q;
      case (cmd_i.out_kind)
        RK_SINGLE: begin
          or_q <= win_q.r; og_q <= win_q.g; ob_q <= win_q.b;
          ocol_q <= 1'b1; ocam_q <= win_q.cam; ow_q <= win_q.w;
        end
        RK_BLEND: begin
          or_q <= quo_q[0]; og_q <= quo_q[1]; ob_q <= quo_q[2];
          ocol_q <= 1'b1; ocam_q <= win_q.cam; ow_q <= win_q.w;
        end
        default: begin
          or_q <= int_q; og_q <= int_q; ob_q <= int_q;
          ocol_q <= 1'b0; ocam_q <= '0; ow_q <= '0;
        end
      endcase
    end
  end

  assign m_valid_o = ov_q;
  assign m_tdata_o = {4'b0, ow_q, ocam_q, ob_q, og_q, or_q, opt_q};
  assign m_tuser_o = ocol_q;

  always_comb begin
    sts_o          = '0;
    sts_o.mode     = mode_q;
    sts_o.pt_ok    = pt_ok;
    sts_o.offer_ok = pt_ok && (c_q.w != '0) && (32'(c_q.cam) < 32'(MAX_CAMERAS));
    sts_o.cnt      = CNT_W'(cnt_rd_q);
    sts_o.keep     = keep;
    sts_o.rd_ge    = rd_q.w >= c_q.w;
    sts_o.blend    = blend_q;
    sts_o.clr_last = clr_addr_q == PA_W'(MAX_POINTS - 1);
    sts_o.div_last = dcnt_q == '0;
    sts_o.out_free = !ov_q || m_ready_i;
  end

endmodule

>>> rtl/core/point_topk_view_blend_core.sv
// ----------------------------------------------------------------------------
// point_topk_view_blend_core
// per-point top-k camera color candidates with weighted blend on finalize
// offer: sorted insertion walk, one entry per cycle
// finalize: gray, single winner or weighted blend (bit-serial divider)
// one item at a time; the output register frees the input while a result waits
// after reset the count memory is swept with tready low
// ----------------------------------------------------------------------------
module point_topk_view_blend_core
  import ptvb_pkg::*;
#(
  parameter int MAX_POINTS  = MaxPointsDef,
  parameter int MAX_KEEP    = MaxKeepDef,
  parameter int MAX_CAMERAS = MaxCamerasDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // point_index, weight, red_in, green_in, blue_in, camera_index, intensity
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // mode
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // point_out, red_out, green_out, blue_out, winner_camera, best_weight
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // colored
  output logic                 m_axis_tuser,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [3:0]           cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  ptvb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ptvb_dp #(
    .MAX_POINTS  (MAX_POINTS),
    .MAX_KEEP    (MAX_KEEP),
    .MAX_CAMERAS (MAX_CAMERAS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule

>>> rtl/core/ptvb_checker.sv
// ----------------------------------------------------------------------------
// ptvb_checker
// port-level checks of the top-k view blend core, bound to the top level
// ----------------------------------------------------------------------------
module ptvb_checker
  import ptvb_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tuser
);

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on consecutive cycles");

  a_gray_no_winner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[59:36] == '0)
    else $error("gray result carries a winner");

  a_gray_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[19:12] == m_axis_tdata[27:20] &&
      m_axis_tdata[27:20] == m_axis_tdata[35:28])
    else $error("gray result channels differ");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind point_topk_view_blend_core ptvb_checker u_ptvb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> tb/sv/point_topk_view_blend_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_topk_view_blend_core_tb
// drives offer and finalize transactions with random gaps and stalls on both
// streams, predicts each finalize color from a per-point top-k list kept in
// the bench, and compares every result field by field in arrival order
// ----------------------------------------------------------------------------
module point_topk_view_blend_core_tb;
  import ptvb_pkg::*;

  localparam int NPT  = 4096;
  localparam int KMAX = 8;
  localparam int NPOOL = 6;
  localparam int WDOG = 200000;

  typedef struct packed {
    logic             mode;
    logic [PT_W-1:0]  pt;
    logic [WT_W-1:0]  w;
    logic [CH_W-1:0]  r;
    logic [CH_W-1:0]  g;
    logic [CH_W-1:0]  b;
    logic [CAM_W-1:0] cam;
    logic [INT_W-1:0] inten;
  } item_t;

  typedef struct packed {
    logic [PT_W-1:0]  pt;
    logic [CH_W-1:0]  r;
    logic [CH_W-1:0]  g;
    logic [CH_W-1:0]  b;
    logic             colored;
    logic [CAM_W-1:0] cam;
    logic [WT_W-1:0]  w;
  } color_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic                 cfg_index_i;
  logic [3:0]           cfg_data_i;

  point_topk_view_blend_core uut (.*);

  item_t  pending_items[$];
  color_t expected_colors[$];
  cand_t  lists[NPT][KMAX];
  int     list_len[NPT];
  logic   blend_mode_m;
  logic [3:0] req_keep_m;
  int     src_idle_pct, snk_idle_pct, hold_cycles, idle_cycles, errors;
  int     n_items, n_results, n_blend;
  bit     cfg_busy;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void add_pending(item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void add_expected(color_t o);
    expected_colors.insert(expected_colors.size(), o);
  endfunction

  function automatic int keep_count();
    int k;
    if (!blend_mode_m) return 1;
    k = (req_keep_m < 2) ? 2 : int'(req_keep_m);
    return (k > KMAX) ? KMAX : k;
  endfunction

  function automatic void place_sorted(int p, int m, cand_t c);
    int pos;
    pos = 0;
    while (pos < m && lists[p][pos].w >= c.w) pos++;
    for (int i = m; i > pos; i--) lists[p][i] = lists[p][i-1];
    lists[p][pos] = c;
  endfunction

  function automatic void track_item(item_t it);
    cand_t c;
    color_t o;
    int p, n;
    longint s, nr, ng, nb;
    p = int'(it.pt);
    if (it.mode == MODE_OFFER) begin
      if (it.w == '0) return;
      c.w = it.w; c.r = it.r; c.g = it.g; c.b = it.b; c.cam = it.cam;
      n = list_len[p];
      if (n < keep_count()) begin
        place_sorted(p, n, c);
        list_len[p] = n + 1;
      end else if (n > 0 && it.w > lists[p][n-1].w) begin
        place_sorted(p, n - 1, c);
      end
      return;
    end
    o = '0;
    o.pt = it.pt;
    n = list_len[p];
    if (n == 0) begin
      o.r = it.inten; o.g = it.inten; o.b = it.inten;
    end else begin
      if (!blend_mode_m || n == 1) begin
        o.r = lists[p][0].r; o.g = lists[p][0].g; o.b = lists[p][0].b;
      end else begin
        s = 0; nr = 0; ng = 0; nb = 0;
        for (int i = 0; i < n; i++) begin
          s  += lists[p][i].w;
          nr += longint'(lists[p][i].w) * lists[p][i].r;
          ng += longint'(lists[p][i].w) * lists[p][i].g;
          nb += longint'(lists[p][i].w) * lists[p][i].b;
        end
        o.r = CH_W'((nr + s / 2) / s);
        o.g = CH_W'((ng + s / 2) / s);
        o.b = CH_W'((nb + s / 2) / s);
        n_blend++;
      end
      o.colored = 1'b1;
      o.cam = lists[p][0].cam;
      o.w = lists[p][0].w;
      list_len[p] = 0;
    end
    add_expected(o);
  endfunction

  function automatic item_t rand_item(bit fin, int p);
    item_t it;
    it.mode = fin ? MODE_FINALIZE : MODE_OFFER;
    it.pt = PT_W'(p);
    it.w = ($urandom_range(0, 9) == 0) ? WT_W'($urandom_range(0, 3)) : WT_W'($urandom);
    if ($urandom_range(0, 7) == 0) it.w = WT_W'(16'h1000 * $urandom_range(1, 3));
    it.r = CH_W'($urandom); it.g = CH_W'($urandom); it.b = CH_W'($urandom);
    it.cam = CAM_W'($urandom); it.inten = INT_W'($urandom);
    return it;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        item_t it;
        it = pending_items.pop_front();
        track_item(it);
        n_items++;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.mode;
        s_axis_tdata  <= {it.inten, it.cam, it.b, it.g, it.r, it.w, it.pt};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready, with an optional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      color_t a, e;
      {a.w, a.cam, a.b, a.g, a.r, a.pt} = m_axis_tdata[59:0];
      a.colored = m_axis_tuser;
      n_results++;
      if (expected_colors.size() == 0) begin
        $display("%0t: result with none expected: %h", $time, a);
        errors++;
      end else begin
        e = expected_colors.pop_front();
        if (a.pt != e.pt) begin
          $display("%0t: point exp %0d act %0d", $time, e.pt, a.pt); errors++;
        end
        if (a.r != e.r) begin
          $display("%0t: red exp %0d act %0d", $time, e.r, a.r); errors++;
        end
        if (a.g != e.g) begin
          $display("%0t: green exp %0d act %0d", $time, e.g, a.g); errors++;
        end
        if (a.b != e.b) begin
          $display("%0t: blue exp %0d act %0d", $time, e.b, a.b); errors++;
        end
        if (a.colored != e.colored) begin
          $display("%0t: colored exp %0d act %0d", $time, e.colored, a.colored); errors++;
        end
        if (a.cam != e.cam) begin
          $display("%0t: camera exp %0d act %0d", $time, e.cam, a.cam); errors++;
        end
        if (a.w != e.w) begin
          $display("%0t: weight exp %0d act %0d", $time, e.w, a.w); errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_busy || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [3:0] val);
    cfg_busy = 1'b1;
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_BLEND_MODE) blend_mode_m = val[0];
    else req_keep_m = val;
    cfg_busy = 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_colors.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_mode(logic bm, logic [3:0] rk);
    drain();
    write_reg(CFG_BLEND_MODE, {3'b000, bm});
    write_reg(CFG_REQ_KEEP, rk);
  endtask

  task automatic queue_random(int count);
    int pool[NPOOL];
    int p, burst;
    for (int i = 0; i < NPOOL; i++) pool[i] = $urandom_range(0, NPT - 1);
    pool[0] = 0; pool[1] = NPT - 1;
    while (count > 0) begin
      p = pool[$urandom_range(0, NPOOL - 1)];
      if ($urandom_range(0, 15) == 0) p = $urandom_range(0, NPT - 1);
      burst = $urandom_range(0, 10);
      for (int j = 0; j < burst; j++) add_pending(rand_item(0, p));
      add_pending(rand_item(1, p));
      count -= burst + 1;
    end
  endtask

  initial begin
    item_t it;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = CFG_BLEND_MODE; cfg_data_i = '0;
    src_idle_pct = 8; snk_idle_pct = 49;
    hold_cycles = 0; idle_cycles = 0; errors = 0;
    n_items = 0; n_results = 0; n_blend = 0; cfg_busy = 1'b0;
    blend_mode_m = 1'b0; req_keep_m = 4'd2;
    for (int i = 0; i < NPT; i++) list_len[i] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // top-1 with reset config: gray, ties, zero weight, extremes
    add_pending(rand_item(1, NPT - 1));
    it = rand_item(0, 5); it.w = 16'd100; it.cam = 8'd0; add_pending(it);
    it = rand_item(0, 5); it.w = 16'd100; it.cam = 8'd255; add_pending(it);
    it = rand_item(0, 5); it.w = 16'd0; add_pending(it);
    it = rand_item(0, 5); it.w = 16'hffff; it.r = 8'hff; it.g = 8'h00; it.b = 8'hff;
    add_pending(it);
    add_pending(rand_item(1, 5));
    set_mode(1'b1, 4'd0);
    it = rand_item(0, 0); it.w = 16'd1; it.r = '0; it.g = '0; it.b = '0;
    add_pending(it);
    it = rand_item(0, 0); it.w = 16'hffff; it.r = 8'hff; it.g = 8'hff; it.b = 8'hff;
    add_pending(it);
    it = rand_item(0, 0); it.w = 16'd1; add_pending(it);
    it = rand_item(0, 0); it.w = 16'd7; add_pending(it);
    add_pending(rand_item(1, 0));
    // single entry in blend mode, then a list longer than a later keep count
    it = rand_item(0, 9); it.w = 16'd300; add_pending(it);
    add_pending(rand_item(1, 9));
    set_mode(1'b1, 4'd8);
    for (int i = 0; i < 8; i++) add_pending(rand_item(0, 11));
    set_mode(1'b1, 4'd3);
    for (int i = 0; i < 4; i++) add_pending(rand_item(0, 11));
    add_pending(rand_item(1, 11));

    // receiver holds off long while the sender keeps offering
    drain();
    hold_cycles = 600;
    queue_random(60);

    set_mode(1'b1, 4'd15);
    queue_random(450);
    set_mode(1'b0, 4'd1);
    queue_random(350);
    src_idle_pct = 49; snk_idle_pct = 8;
    set_mode(1'b1, 4'd5);
    queue_random(450);
    src_idle_pct = 0; snk_idle_pct = 0;
    set_mode(1'b1, 4'd2);
    queue_random(650);
    drain();
    repeat (60) @(posedge clk_i);

    $display("run: %0d items, %0d results (%0d blended), keep 1 to 8 and top-1",
             n_items, n_results, n_blend);
    if (errors == 0 && expected_colors.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
